FILE: design/rrba_pkg.sv
// Package for the rational reduction block: widths, limits, state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrba_pkg;
  localparam int unsigned WordW = 63;
  localparam int unsigned PartW = 31;
  localparam int unsigned ExpW = 8;
  localparam longint unsigned PartLimitDef = 64'd2147483647;
  localparam longint unsigned SmallLimitDef = 64'd65535;
  localparam int unsigned StepLimitDef = 200;
  localparam logic [63:0] SatCap = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_STEP, ST_MUL_N, ST_WAIT_N, ST_WAIT_NR, ST_WAIT_DR,
    ST_UPD, ST_PICK, ST_KDIV, ST_WAIT_K, ST_SCALE_N, ST_WAIT_SN, ST_WAIT_SD,
    ST_DONE
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  // Full 128-bit product held within SatCap.
  function automatic logic [63:0] sat_cap(input logic [127:0] p);
    if (p > {64'd0, SatCap}) return SatCap;
    return p[63:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/rrba_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rrba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrba_div
  import rrba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_req_t    req_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      rem_d = '0; quo_d = req_i.dividend; dvs_d = req_i.divisor;
      cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
      if (!trial[64]) rem_d = trial[63:0];
      else rem_d = {rem_q[62:0], quo_q[63]};
      quo_d = {quo_q[62:0], ~trial[64]};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_busy_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy at done");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'd64) else $error("divider count out of range");
endmodule
`default_nettype wire

FILE: design/rational_reduce_best_approximation.sv
// Top level of the rational reduction block: sequencer, the shared multiplier
// and the shared divider. Depends on rrba_pkg and rrba_div.
//
// Usage: drive numerator_i, denominator_i and exponent_in_i and raise start
// while busy is low; the request is taken at that rising edge and busy goes
// high. The result appears on reduced_num_o, reduced_den_o, exponent_out_o
// and bad_input_o for exactly one cycle, marked by done_o; the receiver
// cannot stall it. busy stays high through the done_o cycle, so one request
// is in work at a time. Special cases (zero denominator, equal parts, zero
// numerator) go from idle straight to the done state, which raises done_o.
// A small folded denominator takes the scale-factor division and two
// multiplications before done_o. Each expansion step takes one division in
// the radix-2 divider, three multiplications built from four 32x32 partial
// products each, and control states. There are up to STEP_LIMIT steps.
// Reset returns the sequencer to idle with busy and done_o low.
`timescale 1ns / 1ps
`default_nettype none
module rational_reduce_best_approximation
  import rrba_pkg::*;
#(
  parameter longint unsigned PART_LIMIT  = PartLimitDef,
  parameter longint unsigned SMALL_LIMIT = SmallLimitDef,
  parameter int unsigned     STEP_LIMIT  = StepLimitDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  output logic                     done_o,
  input  wire logic [WordW-1:0]    numerator_i,
  input  wire logic [WordW-1:0]    denominator_i,
  input  wire logic signed [ExpW-1:0] exponent_in_i,
  output logic [PartW-1:0]         reduced_num_o,
  output logic [PartW-1:0]         reduced_den_o,
  output logic signed [ExpW-1:0]   exponent_out_o,
  output logic                     bad_input_o
);
  state_e      state_q, state_d;
  logic [63:0] n_q, n_d, d_q, d_d, lim_q, lim_d, g_q, g_d;
  logic [63:0] nr_q [4], nr_d [4], dr_q [4], dr_d [4];
  logic [63:0] seln_q, seln_d, seld_q, seld_d, k_q, k_d, pn_q, pn_d;
  logic [8:0]  cnt_q, cnt_d, cap_q, cap_d;
  logic [2:0]  pick_q, pick_d;
  logic [1:0]  fold_q, fold_d; // [1]: swapped, [0]: doubled
  logic        run_q, run_d;
  logic [PartW-1:0] on_q, on_d, od_q, od_d;
  logic [ExpW-1:0]  ex_q, ex_d;
  logic        bad_q, bad_d, done_q, done_d;
  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot;
  logic [1:0]  c0, c1, c2, cp;
  logic        mstart;
  logic [63:0] mul_a, mul_b, ma_q, ma_d, mb_q, mb_d;
  logic [127:0] macc_q, macc_d, mpp_sh;
  logic [1:0]  midx_q, midx_d;
  logic        mbusy_q, mbusy_d, mdone_q, mdone_d;
  logic [31:0] mpart_a, mpart_b;
  logic [63:0] mpp;
  logic [7:0]  mshift;
  logic [63:0] prod, mres, step_p;
  logic [63:0] nt, dt, pd_v, on_v, od_v;

  rrba_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  assign c0 = cnt_q[1:0];
  assign c1 = cnt_q[1:0] - 2'd1;
  assign c2 = cnt_q[1:0] - 2'd2;
  assign cp = cnt_q[1:0] - pick_q[1:0];

  // Shared multiplier: one 32x32 partial product per cycle, four per full product.
  always_comb begin
    ma_d = ma_q; mb_d = mb_q; macc_d = macc_q; midx_d = midx_q;
    mbusy_d = mbusy_q; mdone_d = 1'b0;
    mpart_a = midx_q[0] ? ma_q[63:32] : ma_q[31:0];
    mpart_b = midx_q[1] ? mb_q[63:32] : mb_q[31:0];
    mpp = {32'd0, mpart_a} * {32'd0, mpart_b};
    mshift = {1'b0, midx_q[1] & midx_q[0], midx_q[1] ^ midx_q[0], 5'd0};
    mpp_sh = {64'd0, mpp} << mshift;
    if (mstart) begin
      ma_d = mul_a; mb_d = mul_b; macc_d = '0; midx_d = '0; mbusy_d = 1'b1;
    end else if (mbusy_q) begin
      macc_d = macc_q + mpp_sh;
      midx_d = midx_q + 2'd1;
      if (midx_q == 2'd3) begin
        mbusy_d = 1'b0; mdone_d = 1'b1;
      end
    end
  end

  // Sequencer: special cases, folding, expansion steps, selection and scaling.
  always_comb begin
    state_d = state_q; n_d = n_q; d_d = d_q; lim_d = lim_q; g_d = g_q;
    nr_d = nr_q; dr_d = dr_q; seln_d = seln_q; seld_d = seld_q; k_d = k_q;
    pn_d = pn_q; cnt_d = cnt_q; cap_d = cap_q; pick_d = pick_q; fold_d = fold_q;
    run_d = run_q; on_d = on_q; od_d = od_q; ex_d = ex_q; bad_d = bad_q;
    done_d = 1'b0;
    dreq = '{start: 1'b0, dividend: d_q, divisor: n_q};
    mstart = 1'b0; mul_a = n_q; mul_b = g_q;
    nt = '0; dt = '0; prod = '0; mres = '0; step_p = '0;
    pd_v = '0; on_v = '0; od_v = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          nt = {1'b0, numerator_i}; dt = {1'b0, denominator_i};
          ex_d = exponent_in_i; bad_d = 1'b0; on_d = '0; od_d = '0;
          lim_d = PART_LIMIT; fold_d = 2'b00;
          if (dt == 64'd0) begin
            bad_d = 1'b1; state_d = ST_DONE;
          end else if (nt == dt) begin
            on_d = PartW'(PART_LIMIT); od_d = PartW'(PART_LIMIT); state_d = ST_DONE;
          end else if (nt == 64'd0) begin
            od_d = PartW'(PART_LIMIT); ex_d = '0; state_d = ST_DONE;
          end else begin
            if (dt > nt) begin
              if (dt - nt > nt) begin
                fold_d = 2'b01; nt = nt << 1; lim_d = PART_LIMIT >> 1;
              end
            end else begin
              if (nt - dt > dt) begin
                fold_d = 2'b11; dt = dt << 1; lim_d = PART_LIMIT >> 1;
              end else fold_d = 2'b10;
              {nt, dt} = {dt, nt};
            end
            n_d = nt; d_d = dt;
            if (dt > SMALL_LIMIT) begin
              nr_d = '{64'd1, 64'd0, 64'd1, 64'd0};
              dr_d = '{64'd0, 64'd1, 64'd0, 64'd1};
              cnt_d = 9'd2; cap_d = 9'(STEP_LIMIT); run_d = 1'b1;
              state_d = ST_DIV;
            end else begin
              seln_d = nt; seld_d = dt; state_d = ST_KDIV;
            end
          end
        end
      end
      ST_DIV: begin
        dreq.start = 1'b1; state_d = ST_STEP;
      end
      ST_STEP: begin
        if (ddone) begin
          g_d = cnt_q[0] ? dquot : dquot + 64'd1;
          state_d = ST_MUL_N;
        end
      end
      ST_MUL_N: begin
        mstart = 1'b1; state_d = ST_WAIT_N;
      end
      ST_WAIT_N: begin
        if (mdone_q) begin
          // Remainder product n*g wraps as in 64-bit arithmetic.
          prod = macc_q[63:0];
          n_d = cnt_q[0] ? d_q - prod : prod - d_q;
          d_d = n_q;
          mstart = 1'b1; mul_a = nr_q[c1];
          state_d = ST_WAIT_NR;
        end
      end
      ST_WAIT_NR: begin
        if (mdone_q) begin
          mres = sat_cap(macc_q);
          if (cnt_q[0]) nr_d[c0] = (mres > nr_q[c2]) ? mres - nr_q[c2] : 64'd0;
          else nr_d[c0] = (mres + nr_q[c2] > SatCap) ? SatCap : mres + nr_q[c2];
          mstart = 1'b1; mul_a = dr_q[c1];
          state_d = ST_WAIT_DR;
        end
      end
      ST_WAIT_DR: begin
        if (mdone_q) begin
          mres = sat_cap(macc_q);
          if (cnt_q[0]) step_p = (mres > dr_q[c2]) ? mres - dr_q[c2] : 64'd0;
          else step_p = (mres + dr_q[c2] > SatCap) ? SatCap : mres + dr_q[c2];
          dr_d[c0] = step_p;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        run_d = run_q;
        if (g_q > lim_q) run_d = 1'b0;
        if (cnt_q > cap_q) run_d = 1'b0;
        if (dr_q[c0] > lim_q) cap_d = cnt_q;
        if (n_q == 64'd0) run_d = 1'b0;
        if (run_d) begin
          cnt_d = cnt_q + 9'd1; state_d = ST_DIV;
        end else begin
          pick_d = '0; seln_d = '0; seld_d = '0; state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        // Newest ring entry whose denominator is below the limit.
        if (pick_q[2]) state_d = ST_KDIV;
        else if (dr_q[cp] < lim_q) begin
          seln_d = nr_q[cp]; seld_d = dr_q[cp]; state_d = ST_KDIV;
        end else pick_d = pick_q + 3'd1;
      end
      ST_KDIV: begin
        if (seld_q == 64'd0) begin
          k_d = '0; state_d = ST_SCALE_N;
        end else begin
          dreq = '{start: 1'b1, dividend: lim_q, divisor: seld_q};
          state_d = ST_WAIT_K;
        end
      end
      ST_WAIT_K: begin
        if (ddone) begin
          k_d = dquot; state_d = ST_SCALE_N;
        end
      end
      ST_SCALE_N: begin
        mstart = 1'b1; mul_a = seln_q; mul_b = k_q;
        state_d = ST_WAIT_SN;
      end
      ST_WAIT_SN: begin
        if (mdone_q) begin
          mres = sat_cap(macc_q);
          pn_d = (mres > PART_LIMIT) ? PART_LIMIT : mres;
          mstart = 1'b1; mul_a = seld_q; mul_b = k_q;
          state_d = ST_WAIT_SD;
        end
      end
      ST_WAIT_SD: begin
        if (mdone_q) begin
          mres = sat_cap(macc_q);
          pd_v = (mres > PART_LIMIT) ? PART_LIMIT : mres;
          if (fold_q[1]) begin
            on_v = fold_q[0] ? ((pd_v << 1) > PART_LIMIT ? PART_LIMIT : pd_v << 1) : pd_v;
            od_v = pn_q;
          end else begin
            on_v = pn_q;
            od_v = fold_q[0] ? ((pd_v << 1) > PART_LIMIT ? PART_LIMIT : pd_v << 1) : pd_v;
          end
          on_d = on_v[PartW-1:0]; od_d = od_v[PartW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; done_q <= 1'b0; run_q <= 1'b0;
      mbusy_q <= 1'b0; mdone_q <= 1'b0; midx_q <= '0;
    end else begin
      state_q <= state_d; done_q <= done_d; run_q <= run_d;
      mbusy_q <= mbusy_d; mdone_q <= mdone_d; midx_q <= midx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; lim_q <= lim_d; g_q <= g_d;
    nr_q <= nr_d; dr_q <= dr_d; seln_q <= seln_d; seld_q <= seld_d;
    k_q <= k_d; pn_q <= pn_d; cnt_q <= cnt_d; cap_q <= cap_d; pick_q <= pick_d;
    fold_q <= fold_d; on_q <= on_d; od_q <= od_d; ex_q <= ex_d; bad_q <= bad_d;
    ma_q <= ma_d; mb_q <= mb_d; macc_q <= macc_d;
  end

  assign busy = (state_q != ST_IDLE) || done_q;
  assign done_o = done_q;
  assign reduced_num_o = on_q;
  assign reduced_den_o = od_q;
  assign exponent_out_o = ex_q;
  assign bad_input_o = bad_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy) else $error("result shown while idle");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q != ST_IDLE) else $error("request dropped");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && bad_q) |-> (on_q == '0 && od_q == '0)) else $error("bad result nonzero");
  a_mul_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone_q |-> !mbusy_q) else $error("multiplier busy at done");
endmodule
`default_nettype wire

FILE: tb/sv/rrba_checker.sv
// Checker for the rational reduction block: predicts every accepted request
// and compares each strobed result with the oldest prediction.
// Depends on rrba_pkg for the port widths.
`timescale 1ns / 1ps
module rrba_checker
  import rrba_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       done_i,
  input  logic [WordW-1:0]           numerator_i,
  input  logic [WordW-1:0]           denominator_i,
  input  logic signed [ExpW-1:0]     exponent_in_i,
  input  logic [PartW-1:0]           reduced_num_i,
  input  logic [PartW-1:0]           reduced_den_i,
  input  logic signed [ExpW-1:0]     exponent_out_i,
  input  logic                       bad_input_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam logic [63:0] Cap = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PartMax = 64'd2147483647;
  localparam logic [63:0] SmallMax = 64'd65535;
  localparam int unsigned StepMax = 200;

  typedef struct packed {
    logic [PartW-1:0]       num;
    logic [PartW-1:0]       den;
    logic signed [ExpW-1:0] expo;
    logic                   bad;
  } fraction_t;

  fraction_t fractions_due[$];
  int errors = 0;

  assign errors_o = errors;
  assign pending_o = fractions_due.size();

  // Product held at the 63-bit cap.
  function automatic logic [63:0] capped_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p > {64'd0, Cap}) ? Cap : p[63:0];
  endfunction

  function automatic logic [63:0] capped_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > Cap) ? Cap : s;
  endfunction

  function automatic logic [63:0] clamp_part(input logic [63:0] v);
    return (v > PartMax) ? PartMax : v;
  endfunction

  // Best approximation with 31-bit parts.
  function automatic fraction_t reduce_ratio(input logic [62:0] num_in,
                                             input logic [62:0] den_in,
                                             input logic signed [7:0] exp_in);
    fraction_t f;
    logic [63:0] n, d, lim, g, prev, k, pn, pd, on, od, sel_n, sel_d, t;
    logic [63:0] nr [4];
    logic [63:0] dr [4];
    int fold;
    int unsigned cnt, cap_cnt, c0, c1, c2, c;
    bit run;
    n = {1'b0, num_in};
    d = {1'b0, den_in};
    lim = PartMax;
    fold = 0;
    sel_n = 0;
    sel_d = 0;
    f.num = '0;
    f.den = '0;
    f.expo = exp_in;
    f.bad = 1'b0;
    if (d == 0) begin
      f.bad = 1'b1;
      return f;
    end
    if (n == d) begin
      f.num = PartMax[30:0];
      f.den = PartMax[30:0];
      return f;
    end
    if (n == 0) begin
      f.den = PartMax[30:0];
      f.expo = '0;
      return f;
    end
    // Fold the ratio below one, doubling the smaller part when far apart.
    if (d > n) begin
      fold = -1;
      if (d - n > n) begin
        fold = -2;
        n = n * 2;
        lim = lim / 2;
      end
    end else begin
      fold = 1;
      if (n - d > d) begin
        fold = 2;
        d = d * 2;
        lim = lim / 2;
      end
      t = n;
      n = d;
      d = t;
    end
    if (d > SmallMax) begin
      nr = '{64'd1, 64'd0, 64'd1, 64'd0};
      dr = '{64'd0, 64'd1, 64'd0, 64'd1};
      cnt = 2;
      cap_cnt = StepMax;
      run = 1'b1;
      // Alternating rounded-up and rounded-down expansion steps.
      while (run) begin
        g = d / n;
        prev = n;
        c0 = cnt & 3;
        c1 = (cnt - 1) & 3;
        c2 = (cnt - 2) & 3;
        if ((cnt & 1) == 0) begin
          g = g + 1;
          n = n * g - d;
          nr[c0] = capped_add(capped_mul(nr[c1], g), nr[c2]);
          dr[c0] = capped_add(capped_mul(dr[c1], g), dr[c2]);
        end else begin
          n = d - n * g;
          t = capped_mul(nr[c1], g);
          nr[c0] = (t > nr[c2]) ? t - nr[c2] : 64'd0;
          t = capped_mul(dr[c1], g);
          dr[c0] = (t > dr[c2]) ? t - dr[c2] : 64'd0;
        end
        d = prev;
        if (g > lim) run = 1'b0;
        if (cnt > cap_cnt) run = 1'b0;
        if (dr[c0] > lim) cap_cnt = cnt;
        if (n == 0) run = 1'b0;
        cnt = cnt + 1;
      end
      cnt = cnt - 1;
      // Newest convergent below the limit.
      for (int i = 0; i < 4; i++) begin
        c = (cnt - i) & 3;
        if (dr[c] < lim) begin
          sel_n = nr[c];
          sel_d = dr[c];
          break;
        end
      end
    end else begin
      sel_n = n;
      sel_d = d;
    end
    k = (sel_d != 0) ? lim / sel_d : 64'd0;
    pn = clamp_part(capped_mul(sel_n, k));
    pd = clamp_part(capped_mul(sel_d, k));
    // Undo the folding.
    if (fold > 0) begin
      on = pd;
      od = pn;
      if (fold > 1) on = clamp_part(on * 2);
    end else begin
      on = pn;
      od = pd;
      if (fold < -1) od = clamp_part(od * 2);
    end
    f.num = on[30:0];
    f.den = od[30:0];
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // Record requests and compare results at each rising edge.
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (fractions_due.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = fractions_due.pop_front();
          if (reduced_num_i !== want.num)
            report_mismatch($sformatf("reduced_num %0d, want %0d", reduced_num_i, want.num));
          if (reduced_den_i !== want.den)
            report_mismatch($sformatf("reduced_den %0d, want %0d", reduced_den_i, want.den));
          if (exponent_out_i !== want.expo)
            report_mismatch($sformatf("exponent_out %0d, want %0d", exponent_out_i, want.expo));
          if (bad_input_i !== want.bad)
            report_mismatch($sformatf("bad_input %0b, want %0b", bad_input_i, want.bad));
        end
      end
      if (start_i && !busy_i)
        fractions_due.push_back(reduce_ratio(numerator_i, denominator_i, exponent_in_i));
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the rational reduction testbench: clock, reset, request stimulus
// and verdict. Depends on rrba_pkg, rrba_checker and the block itself.
`timescale 1ns / 1ps
module testbench;
  import rrba_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   done_o;
  logic [WordW-1:0]       numerator_i;
  logic [WordW-1:0]       denominator_i;
  logic signed [ExpW-1:0] exponent_in_i;
  logic [PartW-1:0]       reduced_num_o;
  logic [PartW-1:0]       reduced_den_o;
  logic signed [ExpW-1:0] exponent_out_o;
  logic                   bad_input_o;
  int                     errors;
  int                     pending;
  int                     burst_left;

  localparam logic [62:0] WordMax = '1;

  rational_reduce_best_approximation i_dut (
    .clk_i, .rst_ni, .start, .busy, .done_o,
    .numerator_i, .denominator_i, .exponent_in_i,
    .reduced_num_o, .reduced_den_o, .exponent_out_o, .bad_input_o
  );

  rrba_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .done_i(done_o),
    .numerator_i, .denominator_i, .exponent_in_i,
    .reduced_num_i(reduced_num_o), .reduced_den_i(reduced_den_o),
    .exponent_out_i(exponent_out_o), .bad_input_i(bad_input_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung block.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Random value of random magnitude, so that all sizes come up.
  function automatic logic [62:0] rand_word();
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    return v >> $urandom_range(0, 62);
  endfunction

  // Issue one request, with bursts of back-to-back requests and random gaps.
  task automatic send_request(input logic [62:0] n, input logic [62:0] d,
                              input logic signed [7:0] e);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    numerator_i = n;
    denominator_i = d;
    exponent_in_i = e;
    start = 1'b1;
    @(negedge clk_i);
    start = 1'b0;
    numerator_i = rand_word();
    denominator_i = rand_word();
    exponent_in_i = ExpW'($urandom);
  endtask

  initial begin
    logic [62:0] a, b;
    start = 1'b0;
    numerator_i = '0;
    denominator_i = '0;
    exponent_in_i = '0;
    burst_left = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: special cases, folds and extremes.
    send_request(63'd5, 63'd0, 8'sd127);
    send_request(63'd0, 63'd0, -8'sd128);
    send_request(WordMax, WordMax, 8'sd3);
    send_request(63'd7, 63'd7, -8'sd1);
    send_request(63'd0, 63'd9, 8'sd44);
    send_request(63'd0, WordMax, -8'sd128);
    send_request(63'd3, 63'd4, 8'sd0);
    send_request(63'd5, 63'd4, 8'sd1);
    send_request(63'd1, 63'd1000, 8'sd2);
    send_request(63'd1000, 63'd1, 8'sd2);
    send_request(63'd1, WordMax, 8'sd127);
    send_request(WordMax, 63'd1, -8'sd128);
    send_request(63'd65535, 63'd65534, 8'sd5);
    send_request(63'd65536, 63'd65537, 8'sd5);
    send_request(63'd1000000, 63'd3000000, 8'sd6);
    send_request(63'd3000000, 63'd1000000, 8'sd6);
    send_request(63'd7540113804746346429, 63'd4660046610375530309, 8'sd0);
    send_request(63'd2971215073, 63'd1836311903, 8'sd0);
    send_request(WordMax - 1, WordMax, 8'sd9);
    send_request(63'd314159265358979, 63'd100000000000000, -8'sd14);
    send_request(63'd1, 63'd2, 8'sd0);
    send_request(63'd123456789012, 63'd987654321098, 8'sd12);

    // Hold off until every result is in.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);

    // Random requests: mixed magnitudes, near-equal, small and zero-denominator pairs.
    repeat (268) begin
      case ($urandom_range(0, 5))
        0: begin
          a = 63'({$urandom, $urandom});
          b = 63'({$urandom, $urandom});
        end
        1: begin
          a = 63'($urandom_range(0, 70000));
          b = 63'($urandom_range(1, 70000));
        end
        2: begin a = rand_word(); b = a + 63'($urandom_range(0, 3)) - 63'd1; end
        3: begin a = rand_word(); b = ($urandom_range(0, 15) == 0) ? 63'd0 : rand_word(); end
        default: begin a = rand_word(); b = rand_word(); end
      endcase
      send_request(a, b, 8'($urandom));
    end

    // Drain and let the block settle.
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rrba_pkg.sv
design/rrba_div.sv
design/rational_reduce_best_approximation.sv
tb/sv/rrba_checker.sv
tb/sv/testbench.sv
